@@ design/epb_pkg.sv @@
`timescale 1ns / 1ps
package epb_pkg;

    localparam int LABELS      = 16;
    localparam int COUNT_SLOTS = 16;
    localparam int KEY_W       = 32;
    localparam int LABEL_W     = 4;
    localparam int CNT_W       = 16;
    localparam int SLOT_W      = $clog2(COUNT_SLOTS);

    // Effective label count: counters exist for COUNT_SLOTS classes only.
    localparam int LABEL_LIMIT = (LABELS > COUNT_SLOTS) ? COUNT_SLOTS :
                                 ((LABELS < 1) ? 1 : LABELS);

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [SLOT_W-1:0]  slot_t;

    localparam cnt_t CNT_MAX   = '1;
    localparam slot_t SLOT_TOP = slot_t'(LABEL_LIMIT - 1);

    typedef struct packed {
        key_t   group_key;
        label_t class_label;
        logic   final_item;
    } item_t;

    // Labels at or above the limit fold into the top class.
    function automatic slot_t class_slot(input label_t label);
        slot_t slot;
        slot = SLOT_TOP;
        if ({1'b0, label} < (LABEL_W + 1)'(LABEL_LIMIT))
        begin
            slot = slot_t'(label);
        end
        return slot;
    endfunction

    function automatic cnt_t sat_inc(input cnt_t val);
        return (val == CNT_MAX) ? val : cnt_t'(val + 1'b1);
    endfunction

    function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

@@ design/epb_in_if.sv @@
`timescale 1ns / 1ps
interface epb_in_if;
    import epb_pkg::*;

    logic   valid;
    logic   ready;
    key_t   group_key;
    label_t class_label;
    logic   final_item;

    modport source (output valid, output group_key, output class_label,
                    output final_item, input ready);
    modport sink   (input valid, input group_key, input class_label,
                    input final_item, output ready);
endinterface

@@ design/epb_out_if.sv @@
`timescale 1ns / 1ps
interface epb_out_if;
    import epb_pkg::*;

    logic valid;
    logic ready;
    cnt_t lower_bound;

    modport source (output valid, output lower_bound, input ready);
    modport sink   (input valid, input lower_bound, output ready);
endinterface

@@ design/equivalent_points_lower_bound_core.sv @@
`timescale 1ns / 1ps
// A final item is registered at input, then its bound in the result register.
// Throughput: 1 item per cycle; the only stall is a final item meeting a full,
//   unaccepted output register.
// Reset: rst_n (async, active low) empties both registers and clears all group
//   and bound state; the block also clears itself after every final item.
module equivalent_points_lower_bound_core (
    input  logic      clk,
    input  logic      rst_n,
    epb_in_if.sink    in_ch,
    epb_out_if.source out_ch
);
    import epb_pkg::*;

    // Input register stage
    logic  s1_valid_reg;
    logic  s1_valid_next;
    item_t s1_item_reg;
    item_t s1_item_next;

    // Result register
    logic  out_valid_reg;
    logic  out_valid_next;
    cnt_t  out_bound_reg;
    cnt_t  out_bound_next;

    logic  in_xfer;
    logic  advance;
    cnt_t  final_bound;

    // An item in the input stage retires unless it is a final item whose
    // result has nowhere to go this cycle.
    assign advance = s1_valid_reg &&
                     (!s1_item_reg.final_item || !out_valid_reg || out_ch.ready);

    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_item_next = s1_item_reg;
        if (in_xfer)
        begin
            s1_item_next.group_key   = in_ch.group_key;
            s1_item_next.class_label = in_ch.class_label;
            s1_item_next.final_item  = in_ch.final_item;
        end

        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Group tracking and bound accumulation, updated once per retired item.
    epb_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (s1_item_reg),
        .final_bound (final_bound)
    );

    always_comb
    begin
        out_bound_next = out_bound_reg;
        out_valid_next = out_valid_reg;
        if (advance && s1_item_reg.final_item)
        begin
            out_bound_next = final_bound;
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.lower_bound = out_bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s1_item_reg   <= s1_item_next;
        out_bound_reg <= out_bound_next;
    end

endmodule

@@ design/epb_accum.sv @@
`timescale 1ns / 1ps
module epb_accum (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  epb_pkg::item_t item,
    output epb_pkg::cnt_t  final_bound
);
    import epb_pkg::*;

    key_t  prev_key_reg;
    logic  have_prev_reg;
    cnt_t  counts_reg [COUNT_SLOTS];
    cnt_t  size_reg;
    cnt_t  largest_reg;
    cnt_t  bound_reg;

    slot_t slot;
    logic  close;
    cnt_t  cur_cnt;
    cnt_t  cur_size;
    cnt_t  cur_large;
    cnt_t  bound_mid;
    cnt_t  cnt_new;
    cnt_t  size_new;
    cnt_t  large_new;

    always_comb
    begin
        slot      = class_slot(item.class_label);
        close     = have_prev_reg && (item.group_key != prev_key_reg);
        cur_cnt   = close ? '0 : counts_reg[slot];
        cur_size  = close ? '0 : size_reg;
        cur_large = close ? '0 : largest_reg;
        // count never exceeds size, so the difference is never negative
        bound_mid = close ? sat_add(bound_reg, cnt_t'(size_reg - largest_reg)) : bound_reg;
        cnt_new   = sat_inc(cur_cnt);
        size_new  = sat_inc(cur_size);
        large_new = (cnt_new > cur_large) ? cnt_new : cur_large;
        final_bound = sat_add(bound_mid, cnt_t'(size_new - large_new));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg  <= '0;
            have_prev_reg <= 1'b0;
            size_reg      <= '0;
            largest_reg   <= '0;
            bound_reg     <= '0;
            for (int i = 0; i < COUNT_SLOTS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (item.final_item)
            begin
                prev_key_reg  <= '0;
                have_prev_reg <= 1'b0;
                size_reg      <= '0;
                largest_reg   <= '0;
                bound_reg     <= '0;
                for (int i = 0; i < COUNT_SLOTS; i++)
                begin
                    counts_reg[i] <= '0;
                end
            end
            else
            begin
                prev_key_reg  <= item.group_key;
                have_prev_reg <= 1'b1;
                size_reg      <= size_new;
                largest_reg   <= large_new;
                bound_reg     <= bound_mid;
                for (int i = 0; i < COUNT_SLOTS; i++)
                begin
                    if (slot_t'(i) == slot)
                    begin
                        counts_reg[i] <= cnt_new;
                    end
                    else if (close)
                    begin
                        counts_reg[i] <= '0;
                    end
                end
            end
        end
    end

endmodule

@@ verif/equivalent_points_bound_checker.sv @@
`timescale 1ns / 1ps
module equivalent_points_bound_checker (
    input  logic clk,
    input  logic rst_n,
    epb_in_if    in_mon,
    epb_out_if   out_mon,
    output int   mismatches,
    output int   bounds_owed,
    output int   bounds_checked,
    output int   saturated_bounds
);
    import epb_pkg::*;

    // shadow of the open group and the summed bound
    key_t   open_key;
    logic   group_open;
    cnt_t   class_tally [COUNT_SLOTS];
    cnt_t   member_count;
    cnt_t   top_tally;
    cnt_t   bound_sum;
    cnt_t   bounds_due [$];

    function automatic void forget_group();
        foreach (class_tally[i])
            class_tally[i] = '0;
        member_count = '0;
        top_tally    = '0;
    endfunction

    function automatic void start_over();
        open_key   = '0;
        group_open = 1'b0;
        bound_sum  = '0;
        forget_group();
    endfunction

    // members no single label can get right are added to the bound
    function automatic void retire_group();
        cnt_t        share;
        int unsigned total;
        share = member_count - top_tally;
        total = int'(bound_sum) + int'(share);
        bound_sum = (total > int'(CNT_MAX)) ? CNT_MAX : cnt_t'(total);
        forget_group();
    endfunction

    function automatic void absorb_instance(input key_t key, input label_t label,
                                            input logic last);
        slot_t slot;
        // labels past the counter range fold into the top class
        slot = (int'(label) >= LABEL_LIMIT) ? slot_t'(LABEL_LIMIT - 1) : slot_t'(label);
        if (group_open && key != open_key)
            retire_group();
        if (class_tally[slot] != CNT_MAX)
            class_tally[slot] = class_tally[slot] + 1'b1;
        if (member_count != CNT_MAX)
            member_count = member_count + 1'b1;
        if (class_tally[slot] > top_tally)
            top_tally = class_tally[slot];
        open_key   = key;
        group_open = 1'b1;
        if (last)
        begin
            retire_group();
            bounds_due = {bounds_due, bound_sum};
            start_over();
        end
    endfunction

    initial
    begin
        start_over();
        mismatches       = 0;
        bounds_owed      = 0;
        bounds_checked   = 0;
        saturated_bounds = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        cnt_t due;
        if (!rst_n)
        begin
            start_over();
            bounds_due.delete();
        end
        else
        begin
            // result side first: a result never belongs to this edge's input
            if (out_mon.valid && out_mon.ready)
            begin
                if (bounds_due.size() == 0)
                begin
                    $error("lower_bound: no bound expected, got %0d", out_mon.lower_bound);
                    mismatches++;
                end
                else
                begin
                    due = bounds_due.pop_front();
                    bounds_checked++;
                    if (due == CNT_MAX)
                        saturated_bounds++;
                    if (out_mon.lower_bound !== due)
                    begin
                        $error("lower_bound: expected %0d, actual %0d",
                               due, out_mon.lower_bound);
                        mismatches++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                absorb_instance(in_mon.group_key, in_mon.class_label, in_mon.final_item);
        end
        bounds_owed = bounds_due.size();
    end

endmodule

@@ verif/equivalent_points_lower_bound_core_test.sv @@
`timescale 1ns / 1ps
module equivalent_points_lower_bound_core_test;
    import epb_pkg::*;

    // Random part size, receiver hold-off length and the no-progress limit.
    // The watchdog limit sits far above the worst gap, stall or hold-off.
    localparam int RANDOM_ITEMS   = 1500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;

    typedef enum int {RX_EAGER, RX_CHOPPY, RX_SLUGGISH} rx_mode_e;

    logic clk;
    logic rst_n;

    epb_in_if  in_ch ();
    epb_out_if out_ch ();

    int  mismatches;
    int  bounds_owed;
    int  bounds_checked;
    int  saturated_bounds;

    // Sender pacing: steady means back-to-back transfers, otherwise bursts
    // of random length separated by random gaps.
    bit  steady;
    int  burst_left;
    int  items_sent;

    // Set by the stimulus, cleared by the receiver once its hold-off is over.
    bit  hold_request;

    int  quiet_cycles;

    equivalent_points_lower_bound_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    equivalent_points_bound_checker i_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_mon           (in_ch),
        .out_mon          (out_ch),
        .mismatches       (mismatches),
        .bounds_owed      (bounds_owed),
        .bounds_checked   (bounds_checked),
        .saturated_bounds (saturated_bounds)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: any stretch with no transfer on either side counts up.
    always @(posedge clk)
    begin
        if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: switches at random between stall patterns, and
    // on request drops ready for a long stretch that it counts itself.
    initial
    begin
        rx_mode_e rx_mode;
        int       mode_left;
        rx_mode       = RX_EAGER;
        mode_left     = 0;
        out_ch.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(30, 150);
            end
            mode_left--;
            case (rx_mode)
                RX_EAGER:    out_ch.ready = 1'b1;
                RX_CHOPPY:   out_ch.ready = ($urandom_range(0, 3) != 0);
                RX_SLUGGISH: out_ch.ready = ($urandom_range(0, 3) == 0);
                default:     out_ch.ready = 1'b1;
            endcase
        end
    end

    // Idle cycles: valid low, payload scrambled so nothing leaks through.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_ch.valid       = 1'b0;
            in_ch.group_key   = key_t'($urandom);
            in_ch.class_label = label_t'($urandom);
            in_ch.final_item  = 1'($urandom);
        end
    endtask

    task automatic pace();
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end
            burst_left--;
        end
    endtask

    // One instance; returns once the block has taken the transfer.
    task automatic send_instance(input key_t key, input label_t label, input logic last);
        pace();
        @(negedge clk);
        in_ch.valid       = 1'b1;
        in_ch.group_key   = key;
        in_ch.class_label = label;
        in_ch.final_item  = last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    // Sender pause until every owed bound has come back.
    task automatic drain();
        idle_cycles(1);
        while (bounds_owed != 0)
            @(negedge clk);
    endtask

    // A data set of the given number of groups, each up to span instances.
    // Keys are mostly fresh, sometimes an extreme, a one-bit neighbor, or a
    // key from two groups back (same key, not adjacent: a separate group).
    // Labels lean on one class per group so the bound stays interesting.
    task automatic random_set(input int groups, input int span);
        key_t   key;
        key_t   prior_key;
        key_t   older_key;
        label_t major;
        label_t label;
        int     len;
        prior_key = $urandom;
        older_key = $urandom;
        for (int g = 0; g < groups; g++)
        begin
            case ($urandom_range(0, 9))
                0:       key = older_key;
                1:       key = '0;
                2:       key = '1;
                3:       key = prior_key ^ (key_t'(1) << $urandom_range(0, KEY_W - 1));
                default: key = $urandom;
            endcase
            len   = $urandom_range(1, span);
            major = label_t'($urandom_range(0, 15));
            for (int i = 0; i < len; i++)
            begin
                label = ($urandom_range(0, 2) != 0) ? major : label_t'($urandom_range(0, 15));
                send_instance(key, label, (g == groups - 1) && (i == len - 1));
            end
            older_key = prior_key;
            prior_key = key;
        end
    endtask

    initial
    begin
        int pick;
        int random_start;
        bit pressed;

        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.group_key   = '0;
        in_ch.class_label = '0;
        in_ch.final_item  = 1'b0;
        steady            = 1'b0;
        burst_left        = 0;
        items_sent        = 0;
        hold_request      = 1'b0;
        quiet_cycles      = 0;
        pressed           = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed sets.
        // lone final instance at the lowest key and label
        send_instance(32'h0000_0000, 4'd0, 1'b1);
        // top key, top label: 3 of 4 agree, one misclassified
        send_instance(32'hffff_ffff, 4'd15, 1'b0);
        send_instance(32'hffff_ffff, 4'd15, 1'b0);
        send_instance(32'hffff_ffff, 4'd15, 1'b0);
        send_instance(32'hffff_ffff, 4'd0, 1'b1);
        // key A returns after key B: a fresh group, not a merge
        send_instance(32'h1234_5678, 4'd1, 1'b0);
        send_instance(32'h1234_5678, 4'd2, 1'b0);
        send_instance(32'h1234_5678, 4'd2, 1'b0);
        send_instance(32'h8765_4321, 4'd5, 1'b0);
        send_instance(32'h1234_5678, 4'd7, 1'b0);
        send_instance(32'h1234_5678, 4'd7, 1'b1);
        // final instance opens a new single-instance group
        send_instance(32'h0f0f_0f0f, 4'd3, 1'b0);
        send_instance(32'h0f0f_0f0f, 4'd4, 1'b0);
        send_instance(32'hf0f0_f0f0, 4'd9, 1'b1);
        // same key as the last set's final: state must have been cleared
        send_instance(32'hf0f0_f0f0, 4'd10, 1'b0);
        send_instance(32'hf0f0_f0f0, 4'd12, 1'b1);
        // two groups whose labels all tie on counts, keys with alternating bit patterns
        send_instance(32'haaaa_aaaa, 4'd6, 1'b0);
        send_instance(32'haaaa_aaaa, 4'd11, 1'b0);
        send_instance(32'h5555_5555, 4'd8, 1'b0);
        send_instance(32'h5555_5555, 4'd14, 1'b0);
        send_instance(32'h5555_5555, 4'd13, 1'b1);
        drain();

        // Random sets; halfway through, the receiver holds off while short
        // sets keep coming so the output fills and input backs up.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (!pressed && items_sent - random_start > RANDOM_ITEMS / 2)
            begin
                pressed = 1'b1;
                drain();
                hold_request = 1'b1;
                steady       = 1'b1;
                repeat (40)
                    random_set(1, 2);
                steady = 1'b0;
                drain();
            end
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 9);
            if (pick < 7)
                random_set($urandom_range(1, 5), $urandom_range(1, 6));
            else if (pick == 7)
                random_set($urandom_range(2, 12), 1);
            else if (pick == 8)
                random_set(1, 1);
            else
                random_set($urandom_range(1, 3), $urandom_range(10, 60));
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (bounds_owed != 0)
            $error("lower_bound: %0d expected bounds never arrived", bounds_owed);

        $display("Ran %0d instances; %0d bounds checked, %0d of them saturated.",
                 items_sent, bounds_checked, saturated_bounds);
        $display("Included directed edge sets, a long receiver hold-off and key reuse.");
        if (mismatches == 0 && bounds_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
design/epb_pkg.sv
design/epb_in_if.sv
design/epb_out_if.sv
design/epb_accum.sv
design/equivalent_points_lower_bound_core.sv
verif/equivalent_points_bound_checker.sv
verif/equivalent_points_lower_bound_core_test.sv
